>>> sv/msts_pkg.sv
// Package for the multi-slot timer scheduler: sizes, command and status codes,
// the layout of one slot entry, and the saturating time adder.
// No dependencies.
package msts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 32;
  localparam int ID_W   = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int PEND_W = 5;

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ONCE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PERIODIC   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL_ALL = 3'd4;

  localparam logic [STAT_W-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FIRED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd3;
  localparam logic [STAT_W-1:0] ST_CANCEL    = 3'd4;

  typedef struct packed {
    logic              periodic;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              set;
    logic              clr;
    logic              clr_all;
    logic [SLOT_W-1:0] idx;
  } live_op_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> sv/multi_slot_timer_scheduler_top.sv
// Top level of the multi-slot timer scheduler: command sequencer, slot scan
// and output register. Depends on msts_pkg, msts_ram and msts_live.
//
// Each input transaction carries one command: tick, schedule once, schedule
// periodic, cancel by id or cancel all. Each command gives exactly one result
// transaction with a status, an id and the number of live slots after it.
// The slot entries live in a RAM; live bits sit in flip-flops. A tick or a
// cancel by id reads every slot in turn through the single RAM read port and
// keeps the best candidate with one comparator, then passes through S_FIN
// and S_OUT into the output register; the next command is accepted once the
// sequencer is back in S_IDLE. Schedule and cancel all need no scan: they
// go from S_IDLE straight to S_FIN, then S_OUT and the output register, and
// the next command again waits until the sequencer is back in S_IDLE.
// One command is in work at a time; in_stall is high while it is. A new
// command is accepted while an earlier result still waits in the output
// register; when out_stall holds that result, the sequencer waits before
// loading the next one. Reset clears all live bits and the id counter, so
// the block needs no clearing pass.
module multi_slot_timer_scheduler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msts_pkg::CMD_W-1:0]    in_cmd,
  input  logic [msts_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [msts_pkg::TIME_W-1:0]   in_delay_ms,
  input  logic [msts_pkg::ID_W-1:0]     in_target_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msts_pkg::STAT_W-1:0]   out_status,
  output logic [msts_pkg::ID_W-1:0]     out_id,
  output logic [msts_pkg::PEND_W-1:0]   out_pending
);
  import msts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] delay_r, delay_nxt;
  logic [ID_W-1:0]   target_r, target_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              best_vld_r, best_vld_nxt;
  entry_t            best_r, best_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]   next_ident_r, next_ident_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [PEND_W-1:0] out_pending_r, out_pending_nxt;

  logic              in_accept;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  live_op_t          live_op;
  logic [SLOTS-1:0]  live;
  logic [CNT_W-1:0]  live_count;
  logic [SLOT_W-1:0] free_idx;
  logic              full;
  logic              out_free;

  msts_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W),
    .AW    (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msts_live u_live (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (live_op),
    .live     (live),
    .count    (live_count),
    .free_idx (free_idx),
    .full     (full)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign ram_re    = (state_r == S_SCAN) && (32'(scan_cnt_r) < 32'(SLOTS));
  assign ram_raddr = scan_cnt_r[SLOT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    now_nxt         = now_r;
    delay_nxt       = delay_r;
    target_nxt      = target_r;
    scan_cnt_nxt    = scan_cnt_r;
    rd_vld_nxt      = ram_re;
    rd_idx_nxt      = ram_raddr;
    best_vld_nxt    = best_vld_r;
    best_nxt        = best_r;
    best_idx_nxt    = best_idx_r;
    next_ident_nxt  = next_ident_r;
    res_status_nxt  = res_status_r;
    res_id_nxt      = res_id_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_pending_nxt = out_pending_r;
    ram_we          = 1'b0;
    ram_waddr       = best_idx_r;
    ram_wdata       = best_r;
    live_op         = '0;
    live_op.idx     = best_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt      = in_cmd;
          now_nxt      = in_now_ms;
          delay_nxt    = in_delay_ms;
          target_nxt   = in_target_id;
          scan_cnt_nxt = '0;
          best_vld_nxt = 1'b0;
          if (in_cmd inside {CMD_TICK, CMD_CANCEL}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        if (rd_vld_r && live[rd_idx_r]) begin
          if (cmd_r == CMD_TICK) begin
            if (!best_vld_r || (rd_entry.deadline < best_r.deadline)) begin
              best_vld_nxt = 1'b1;
              best_nxt     = rd_entry;
              best_idx_nxt = rd_idx_r;
            end
          end else if (!best_vld_r && (rd_entry.ident == target_r)) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = rd_idx_r;
          end
        end
        if (!ram_re && !rd_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_status_nxt = ST_NONE;
        res_id_nxt     = '0;
        case (cmd_r)
          CMD_TICK: begin
            if (best_vld_r && (best_r.deadline <= now_r)) begin
              res_status_nxt = ST_FIRED;
              res_id_nxt     = best_r.ident;
              if (best_r.periodic) begin
                ram_we             = 1'b1;
                ram_wdata.deadline = sat_add(now_r, best_r.period);
              end else begin
                live_op.clr = 1'b1;
              end
            end
          end
          CMD_ONCE, CMD_PERIODIC: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = free_idx;
              ram_wdata.periodic = (cmd_r == CMD_PERIODIC);
              ram_wdata.period   = (cmd_r == CMD_PERIODIC) ? delay_r : '0;
              ram_wdata.deadline = sat_add(now_r, delay_r);
              ram_wdata.ident    = next_ident_r;
              live_op.set        = 1'b1;
              live_op.idx        = free_idx;
              res_status_nxt     = ST_SCHEDULED;
              res_id_nxt         = next_ident_r;
              next_ident_nxt     = next_ident_r + ID_W'(1);
            end
          end
          CMD_CANCEL: begin
            live_op.clr    = best_vld_r;
            res_status_nxt = ST_CANCEL;
            res_id_nxt     = target_r;
          end
          CMD_CANCEL_ALL: begin
            live_op.clr_all = 1'b1;
            res_status_nxt  = ST_CANCEL;
          end
          default: begin
            res_status_nxt = ST_NONE;
          end
        endcase
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_id_nxt      = res_id_r;
          out_pending_nxt = (32'(live_count) > 32'd31) ? PEND_W'(31) : PEND_W'(live_count);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_vld_r     <= 1'b0;
      next_ident_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      next_ident_r <= next_ident_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    now_r         <= now_nxt;
    delay_r       <= delay_nxt;
    target_r      <= target_nxt;
    scan_cnt_r    <= scan_cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_vld_r    <= best_vld_nxt;
    best_r        <= best_nxt;
    best_idx_r    <= best_idx_nxt;
    res_status_r  <= res_status_nxt;
    res_id_r      <= res_id_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_pending_r <= out_pending_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_id      = out_id_r;
  assign out_pending = out_pending_r;

endmodule

>>> sv/msts_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered
// read port. No dependencies.
module msts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/msts_live.sv
// Live bits of the timer slots, the count of live slots and the lowest free
// slot. Depends on msts_pkg.
module msts_live (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msts_pkg::live_op_t            op,
  output logic [msts_pkg::SLOTS-1:0]    live,
  output logic [msts_pkg::CNT_W-1:0]    count,
  output logic [msts_pkg::SLOT_W-1:0]   free_idx,
  output logic                          full
);
  import msts_pkg::*;

  logic [SLOTS-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    live_nxt  = live_r;
    count_nxt = count_r;
    if (op.clr_all) begin
      live_nxt  = '0;
      count_nxt = '0;
    end else if (op.set && !live_r[op.idx]) begin
      live_nxt[op.idx] = 1'b1;
      count_nxt        = count_r + CNT_W'(1);
    end else if (op.clr && live_r[op.idx]) begin
      live_nxt[op.idx] = 1'b0;
      count_nxt        = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      count_r <= '0;
    end else begin
      live_r  <= live_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign full  = &live_r;
  assign live  = live_r;
  assign count = count_r;

endmodule
